// ===== rtl/core/olir_pkg.sv =====
// Shared types and codes for the ordered list insert/remove block.
package olir_pkg;

   localparam int CAPACITY_DEF = 256;
   localparam int ENTRY_W      = 32;
   localparam int COUNT_W      = 9;

   // Operation codes carried on req_tuser
   localparam logic [2:0] MODE_INS_FRONT  = 3'd0;
   localparam logic [2:0] MODE_INS_END    = 3'd1;
   localparam logic [2:0] MODE_INS_AT     = 3'd2;
   localparam logic [2:0] MODE_REM_FRONT  = 3'd3;
   localparam logic [2:0] MODE_REM_END    = 3'd4;
   localparam logic [2:0] MODE_REM_SECOND = 3'd5;
   localparam logic [2:0] MODE_CLEAR      = 3'd6;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_POS  = 2'd2,
      ST_FEW  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2,
      CELL_CLEAR  = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [ENTRY_W-1:0] value;
   } cell_cmd_type;

endpackage

// ===== rtl/core/olir_cell.sv =====
// One slot of the list: holds an entry and shifts to or from its neighbors.
module olir_cell
   import olir_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int INDEX    = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cell_cmd_type                       cmd,
   input  logic [$clog2(CAPACITY+1)-1:0]      at,
   input  logic [$clog2(CAPACITY+1)-1:0]      used,
   input  logic signed [ENTRY_W-1:0]          left_data,
   input  logic signed [ENTRY_W-1:0]          right_data,
   output logic signed [ENTRY_W-1:0]          data
);

   localparam int CNT_W = $clog2(CAPACITY+1);
   localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(INDEX + 1);

   logic signed [ENTRY_W-1:0] data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (MY_IDX == at) begin
               data_in = cmd.value;
            end else if (MY_IDX > at && MY_IDX <= used) begin
               data_in = left_data;
            end
         end
         CELL_REMOVE: begin
            if (MY_IDX >= at && MY_NEXT < used) begin
               data_in = right_data;
            end else if (MY_NEXT == used) begin
               data_in = '0;
            end
         end
         CELL_CLEAR: data_in = '0;
         default:    data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule

// ===== rtl/core/olir_ctrl.sv =====
// Operation decode: status, new length and the command broadcast to the cells.
module olir_ctrl
   import olir_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                              fire,
   input  logic [2:0]                        mode,
   input  logic [7:0]                        position,
   input  logic signed [ENTRY_W-1:0]         value,
   input  logic [$clog2(CAPACITY+1)-1:0]     used,
   output status_type                        status,
   output logic [$clog2(CAPACITY+1)-1:0]     used_next,
   output logic [$clog2(CAPACITY+1)-1:0]     at,
   output cell_cmd_type                      cmd
);

   localparam int CNT_W = $clog2(CAPACITY+1);
   localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

   logic             full;
   logic [CMP_W-1:0] pos_w, used_w;
   cell_op_type      op;

   assign full   = (used >= CNT_W'(CAPACITY));
   assign pos_w  = CMP_W'(position);
   assign used_w = CMP_W'(used);

   always_comb begin
      status    = ST_OK;
      used_next = used;
      at        = '0;
      op        = CELL_HOLD;
      unique case (mode)
         MODE_INS_FRONT, MODE_INS_END: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               op        = CELL_INSERT;
               at        = (mode == MODE_INS_END) ? used : '0;
               used_next = used + CNT_W'(1);
            end
         end
         MODE_INS_AT: begin
            if (full) begin
               status = ST_FULL;
            end else if (pos_w >= used_w) begin
               status = ST_POS;
            end else begin
               op        = CELL_INSERT;
               at        = CNT_W'(position);
               used_next = used + CNT_W'(1);
            end
         end
         MODE_REM_FRONT, MODE_REM_END: begin
            if (used == '0) begin
               status = ST_FEW;
            end else begin
               op        = CELL_REMOVE;
               at        = (mode == MODE_REM_END) ? used - CNT_W'(1) : '0;
               used_next = used - CNT_W'(1);
            end
         end
         MODE_REM_SECOND: begin
            if (used < CNT_W'(2)) begin
               status = ST_FEW;
            end else begin
               op        = CELL_REMOVE;
               at        = used - CNT_W'(2);
               used_next = used - CNT_W'(1);
            end
         end
         MODE_CLEAR: begin
            op        = CELL_CLEAR;
            used_next = '0;
         end
         default: begin
            status = ST_OK;
         end
      endcase
      cmd.op    = fire ? op : CELL_HOLD;
      cmd.value = value;
   end

endmodule

// ===== rtl/core/ordered_list_insert_remove.sv =====
// Ordered list with shift-based insert and remove, built as a row of cells.
//
//  channel | dir | handshake            | word
//  --------+-----+----------------------+----------------------------------
//  req     | in  | req_tvalid/tready    | tuser mode, tdata position,value
//  rsp     | out | rsp_tvalid/tready    | tdata status,count
//
// One operation per cycle: every cell shifts at once, so the only per-word
// work is the decode in the controller and a single register stage.
// A new word is taken while the response register is empty or being drained.
// A stalled response holds its word and stops further requests.
// Synchronous active-high reset empties the list and zeroes every cell.
module ordered_list_insert_remove
   import olir_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // [2:0] mode
   input  logic [39:0] req_tdata,   // [7:0] position, [39:8] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [1:0] status, [10:2] count, rest zero
);

   localparam int CNT_W = $clog2(CAPACITY+1);

   logic                      fire;
   status_type                status;
   logic [CNT_W-1:0]          used_ff, used_in, used_next, at;
   cell_cmd_type              cmd;
   logic signed [ENTRY_W-1:0] cell_data [CAPACITY];

   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;

   olir_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .fire      (fire),
      .mode      (req_tuser),
      .position  (req_tdata[7:0]),
      .value     (req_tdata[39:8]),
      .used      (used_ff),
      .status    (status),
      .used_next (used_next),
      .at        (at),
      .cmd       (cmd)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [ENTRY_W-1:0] left_d, right_d;
      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_left
         assign left_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_right
         assign right_d = cell_data[i+1];
      end
      olir_cell #(.CAPACITY(CAPACITY), .INDEX(i)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .at         (at),
         .used       (used_ff),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[i])
      );
   end

   assign used_in      = fire ? used_next : used_ff;
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff <= status;
         rsp_count_ff  <= COUNT_W'(used_next);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_count_ff, rsp_status_ff};

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_tvalid && rsp_tdata[10:2] == COUNT_W'(used_ff))
      else $error("response count differs from held length");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      fire && status != ST_OK |=> used_ff == $past(used_ff))
      else $error("rejected operation changed the length");

   a_tail_zero: assert property (@(posedge clock) disable iff (reset)
      cell_data[CAPACITY-1] != '0 |-> used_ff == CNT_W'(CAPACITY))
      else $error("slot past the list end holds data");
`endif

endmodule
